FILE: rtl/icld_pkg.sv
package icld_pkg;

  localparam int MAX_LINE = 64;
  localparam int HEAD_LEN = 7;
  localparam int NUM_CNT = 3;
  localparam int NUM_LIT = 4;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_1 = 8'h31;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_J = 8'h4a;
  localparam logic [7:0] CH_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [3:0] RANGE_LIMIT = 4'd6;

  localparam logic [3:0] CMD_UNKNOWN = 4'd0;
  localparam logic [3:0] CMD_IDN = 4'd1;
  localparam logic [3:0] CMD_MEAS = 4'd2;
  localparam logic [3:0] CMD_INFO = 4'd3;
  localparam logic [3:0] CMD_RANGE_I = 4'd4;
  localparam logic [3:0] CMD_RANGE_J = 4'd5;
  localparam logic [3:0] CMD_RANGE_IJ = 4'd6;
  localparam logic [3:0] CMD_ZERO = 4'd7;
  localparam logic [3:0] CMD_UPGRADE = 4'd8;

  localparam logic [2:0] PH_TOKEN = 3'd0;
  localparam logic [2:0] PH_NUM0 = 3'd1;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam logic [1:0] LAST_NUM = 2'd2;

  localparam logic [7:0] LIT_TEXT [NUM_LIT][HEAD_LEN] = '{
    '{8'h2a, 8'h49, 8'h44, 8'h4e, 8'h3f, 8'h00, 8'h00},
    '{8'h4d, 8'h45, 8'h41, 8'h53, 8'h3f, 8'h00, 8'h00},
    '{8'h49, 8'h4e, 8'h46, 8'h4f, 8'h3f, 8'h00, 8'h00},
    '{8'h55, 8'h50, 8'h47, 8'h52, 8'h41, 8'h44, 8'h45}
  };
  localparam logic [2:0] LIT_LEN [NUM_LIT] = '{3'd5, 3'd5, 3'd5, 3'd7};

  typedef struct packed {
    logic                             ovf;
    logic                             len_eq2;
    logic                             len_eq3;
    logic                             len_eq5;
    logic                             len_gt7;
    logic [NUM_LIT-1:0]               flags;
    logic                             num_err;
    logic [NUM_CNT-1:0]               seen;
    logic [HEAD_LEN-1:0][7:0]         head;
    logic [NUM_CNT-1:0][31:0]         acc;
  } line_sum_t;

  typedef struct packed {
    logic [3:0]  cmd_code;
    logic [2:0]  range_arg;
    logic        zero_channel;
    logic        zero_on;
    logic [31:0] fw_version;
    logic [31:0] fw_size;
    logic [31:0] fw_crc;
  } result_t;

endpackage

FILE: rtl/icld_line.sv
module icld_line
  import icld_pkg::*;
#(
  parameter int MaxLine = MAX_LINE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_fire,
  input  logic [7:0] rx_byte,
  output logic       line_done,
  output line_sum_t  line_sum
);

  localparam int LW = $clog2(MaxLine);

  logic [LW-1:0]        len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [7:0]           head_r [HEAD_LEN];
  logic [7:0]           head_nxt [HEAD_LEN];
  logic [NUM_LIT-1:0]   flags_r, flags_nxt;
  logic [2:0]           phase_r, phase_nxt;
  logic [31:0]          acc_r [NUM_CNT];
  logic [31:0]          acc_nxt [NUM_CNT];
  logic [NUM_CNT-1:0]   seen_r, seen_nxt;
  logic                 err_r, err_nxt;

  logic [7:0] c;
  logic       term;
  logic       ws;
  logic       dig;
  logic [1:0] k;
  logic [31:0] digit;

  always_comb begin
    c = rx_byte;
    if (rx_byte >= CH_LOW_A && rx_byte <= CH_LOW_Z) begin
      c = rx_byte - CASE_OFFSET;
    end
    term = (c == CH_CR) || (c == CH_LF);
    ws = (c == CH_SPACE) || (c == CH_TAB);
    dig = (c >= CH_DIG_0) && (c <= CH_DIG_9);
    digit = {24'd0, c - CH_DIG_0};
    k = 2'(phase_r - PH_NUM0);
  end

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    head_nxt = head_r;
    flags_nxt = flags_r;
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    seen_nxt = seen_r;
    err_nxt = err_r;
    line_done = 1'b0;
    if (byte_fire) begin
      if (term) begin
        if (len_r != '0 || ovf_r) begin
          line_done = 1'b1;
          len_nxt = '0;
          ovf_nxt = 1'b0;
          for (int i = 0; i < HEAD_LEN; i++) begin
            head_nxt[i] = 8'd0;
          end
          flags_nxt = '1;
          phase_nxt = PH_TOKEN;
          for (int i = 0; i < NUM_CNT; i++) begin
            acc_nxt[i] = 32'd0;
          end
          seen_nxt = '0;
          err_nxt = 1'b0;
        end
      end else if (ovf_r || len_r >= LW'(MaxLine - 1)) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + 1'b1;
        if (len_r < LW'(HEAD_LEN)) begin
          head_nxt[len_r[2:0]] = c;
        end
        for (int i = 0; i < NUM_LIT; i++) begin
          if (len_r < LW'(LIT_LEN[i])) begin
            if (c != LIT_TEXT[i][len_r[2:0]]) begin
              flags_nxt[i] = 1'b0;
            end
          end else if (i < NUM_LIT - 1) begin
            flags_nxt[i] = 1'b0;
          end
        end
        if (!err_r && phase_r < PH_DONE) begin
          if (phase_r == PH_TOKEN) begin
            if (ws) begin
              phase_nxt = PH_NUM0;
            end
          end else if (!seen_r[k]) begin
            if (dig) begin
              seen_nxt[k] = 1'b1;
              acc_nxt[k] = digit;
            end else if (!ws) begin
              err_nxt = 1'b1;
            end
          end else if (dig) begin
            acc_nxt[k] = (acc_r[k] << 3) + (acc_r[k] << 1) + digit;
          end else if (ws || k == LAST_NUM) begin
            phase_nxt = phase_r + 3'd1;
          end else begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_r[i] <= 8'd0;
      end
      flags_r <= '1;
      phase_r <= PH_TOKEN;
      for (int i = 0; i < NUM_CNT; i++) begin
        acc_r[i] <= 32'd0;
      end
      seen_r <= '0;
      err_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      head_r <= head_nxt;
      flags_r <= flags_nxt;
      phase_r <= phase_nxt;
      acc_r <= acc_nxt;
      seen_r <= seen_nxt;
      err_r <= err_nxt;
    end
  end

  always_comb begin
    line_sum.ovf = ovf_r;
    line_sum.len_eq2 = (len_r == LW'(2));
    line_sum.len_eq3 = (len_r == LW'(3));
    line_sum.len_eq5 = (len_r == LW'(5));
    line_sum.len_gt7 = (len_r > LW'(7));
    line_sum.flags = flags_r;
    line_sum.num_err = err_r;
    line_sum.seen = seen_r;
    for (int i = 0; i < HEAD_LEN; i++) begin
      line_sum.head[i] = head_r[i];
    end
    for (int i = 0; i < NUM_CNT; i++) begin
      line_sum.acc[i] = acc_r[i];
    end
  end

endmodule

FILE: rtl/icld_decode.sv
module icld_decode
  import icld_pkg::*;
(
  input  line_sum_t line_sum,
  output result_t   result
);

  logic [3:0] arg1;
  logic [3:0] arg2;
  logic [7:0] h0;
  logic [7:0] h1;
  logic [7:0] h2;

  always_comb begin
    h0 = line_sum.head[0];
    h1 = line_sum.head[1];
    h2 = line_sum.head[2];
    arg1 = h1[3:0];
    arg2 = h2[3:0];
    result = '0;
    result.cmd_code = CMD_UNKNOWN;
    if (!line_sum.ovf) begin
      if (line_sum.len_eq5 && line_sum.flags[0]) begin
        result.cmd_code = CMD_IDN;
      end else if (line_sum.len_eq5 && line_sum.flags[1]) begin
        result.cmd_code = CMD_MEAS;
      end else if (line_sum.len_eq5 && line_sum.flags[2]) begin
        result.cmd_code = CMD_INFO;
      end else if (line_sum.len_eq2 && arg1 < RANGE_LIMIT && (h0 == CH_I || h0 == CH_J)) begin
        result.cmd_code = (h0 == CH_I) ? CMD_RANGE_I : CMD_RANGE_J;
        result.range_arg = arg1[2:0];
      end else if (line_sum.len_eq3 && h0 == CH_I && h1 == CH_J && arg2 < RANGE_LIMIT) begin
        result.cmd_code = CMD_RANGE_IJ;
        result.range_arg = arg2[2:0];
      end else if (line_sum.len_eq3 && h0 == CH_Z && (h1 == CH_I || h1 == CH_J)
                   && (h2 == CH_DIG_0 || h2 == CH_DIG_1)) begin
        result.cmd_code = CMD_ZERO;
        result.zero_channel = (h1 == CH_J);
        result.zero_on = (h2 == CH_DIG_1);
      end else if (line_sum.len_gt7 && line_sum.flags[3] && !line_sum.num_err
                   && line_sum.seen[2]) begin
        result.cmd_code = CMD_UPGRADE;
        result.fw_version = line_sum.acc[0];
        result.fw_size = line_sum.acc[1];
        result.fw_crc = line_sum.acc[2];
      end
    end
  end

endmodule

FILE: rtl/icld_outbuf.sv
module icld_outbuf
  import icld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    take;

  always_comb begin
    take = out_valid_r && !out_stall;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt = skid_data_r;
    if (take) begin
      if (skid_valid_r) begin
        out_data_nxt = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

FILE: rtl/instrument_command_line_decoder.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_rx_byte
// out_      output     out_valid/out_stall out_cmd_code, out_range_arg, out_zero_channel,
//                                          out_zero_on, out_fw_version, out_fw_size, out_fw_crc
//
// One input beat is taken every cycle while in_stall is low; a line end is decoded from the
// line registers into the result register, or into the skid entry if its beat is not taken.
// The result register is backed by one skid entry; in_stall rises only while that skid entry
// is occupied, which happens only when two results are waiting on a stalled output.
// Reset is synchronous and active low; it empties both result entries and clears the line.
module instrument_command_line_decoder
  import icld_pkg::*;
#(
  parameter int MaxLine = MAX_LINE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_cmd_code,
  output logic [2:0]  out_range_arg,
  output logic        out_zero_channel,
  output logic        out_zero_on,
  output logic [31:0] out_fw_version,
  output logic [31:0] out_fw_size,
  output logic [31:0] out_fw_crc
);

  logic      byte_fire;
  logic      line_done;
  line_sum_t line_sum;
  result_t   dec_result;
  result_t   out_data;
  logic      buf_full;

  assign in_stall = buf_full;
  assign byte_fire = in_valid && !buf_full;

  icld_line #(
    .MaxLine(MaxLine)
  ) u_line (
    .clk(clk),
    .rst_n(rst_n),
    .byte_fire(byte_fire),
    .rx_byte(in_rx_byte),
    .line_done(line_done),
    .line_sum(line_sum)
  );

  icld_decode u_decode (
    .line_sum(line_sum),
    .result(dec_result)
  );

  icld_outbuf u_outbuf (
    .clk(clk),
    .rst_n(rst_n),
    .push(line_done),
    .push_data(dec_result),
    .full(buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  assign out_cmd_code = out_data.cmd_code;
  assign out_range_arg = out_data.range_arg;
  assign out_zero_channel = out_data.zero_channel;
  assign out_zero_on = out_data.zero_on;
  assign out_fw_version = out_data.fw_version;
  assign out_fw_size = out_data.fw_size;
  assign out_fw_crc = out_data.fw_crc;

endmodule

FILE: bench/tb_instrument_command_line_decoder.sv
module tb_instrument_command_line_decoder;
  import icld_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 700;
  localparam int HOLD_CYCLES = 250;

  localparam int KW_IDN = 0;
  localparam int KW_MEAS = 1;
  localparam int KW_INFO = 2;
  localparam int KW_UPGRADE = 3;

  localparam int STALL_NONE = 0;
  localparam int STALL_ALT = 1;
  localparam int STALL_LIGHT = 2;
  localparam int STALL_HEAVY = 3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_cmd_code;
  logic [2:0]  out_range_arg;
  logic        out_zero_channel;
  logic        out_zero_on;
  logic [31:0] out_fw_version;
  logic [31:0] out_fw_size;
  logic [31:0] out_fw_crc;

  // Line decoder state kept by the bench.
  logic [6:0]  ln_len;
  logic        ln_ovf;
  logic [7:0]  ln_head [HEAD_LEN];
  logic [3:0]  ln_kw;
  logic [2:0]  ln_phase;
  logic [31:0] ln_num [NUM_CNT];
  logic [2:0]  ln_seen;
  logic        ln_bad;

  result_t     expected_cmds [$];
  logic [7:0]  line_buf [$];

  int errors = 0;
  int cycle_count = 0;
  int bytes_used = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_mode = STALL_NONE;
  int rx_mode_left = 0;

  instrument_command_line_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cmd_code(out_cmd_code),
    .out_range_arg(out_range_arg),
    .out_zero_channel(out_zero_channel),
    .out_zero_on(out_zero_on),
    .out_fw_version(out_fw_version),
    .out_fw_size(out_fw_size),
    .out_fw_crc(out_fw_crc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic string keyword_text(input int k);
    case (k)
      KW_IDN: return "*IDN?";
      KW_MEAS: return "MEAS?";
      KW_INFO: return "INFO?";
      default: return "UPGRADE";
    endcase
  endfunction

  task automatic clear_line_state();
    int i;
    ln_len = '0;
    ln_ovf = 1'b0;
    for (i = 0; i < HEAD_LEN; i++) ln_head[i] = 8'h00;
    ln_kw = 4'hF;
    ln_phase = PH_TOKEN;
    for (i = 0; i < NUM_CNT; i++) ln_num[i] = '0;
    ln_seen = '0;
    ln_bad = 1'b0;
  endtask

  task automatic feed_upgrade_numbers(input logic [7:0] c);
    logic ws;
    logic dig;
    logic [7:0] dval;
    int k;
    ws = (c == CH_SPACE) || (c == CH_TAB);
    dig = (c >= CH_DIG_0) && (c <= CH_DIG_9);
    dval = c - CH_DIG_0;
    if (!ln_bad && ln_phase < PH_DONE) begin
      if (ln_phase == PH_TOKEN) begin
        if (ws) ln_phase = PH_NUM0;
      end else begin
        k = int'(ln_phase - PH_NUM0);
        if (!ln_seen[k]) begin
          if (dig) begin
            ln_seen[k] = 1'b1;
            ln_num[k] = {24'd0, dval};
          end else if (!ws) begin
            ln_bad = 1'b1;
          end
        end else if (dig) begin
          ln_num[k] = ln_num[k] * 32'd10 + {24'd0, dval};
        end else if (ws || k == LAST_NUM) begin
          ln_phase = ln_phase + 3'd1;
        end else begin
          ln_bad = 1'b1;
        end
      end
    end
  endtask

  function automatic result_t decode_line_state();
    result_t r;
    logic [3:0] arg2;
    logic [3:0] arg3;
    r = '0;
    arg2 = ln_head[1][3:0];
    arg3 = ln_head[2][3:0];
    if (ln_ovf) begin
      r.cmd_code = CMD_UNKNOWN;
    end else if (ln_len == 5 && ln_kw[KW_IDN]) begin
      r.cmd_code = CMD_IDN;
    end else if (ln_len == 5 && ln_kw[KW_MEAS]) begin
      r.cmd_code = CMD_MEAS;
    end else if (ln_len == 5 && ln_kw[KW_INFO]) begin
      r.cmd_code = CMD_INFO;
    end else if (ln_len == 2 && arg2 < RANGE_LIMIT
                 && (ln_head[0] == CH_I || ln_head[0] == CH_J)) begin
      r.cmd_code = (ln_head[0] == CH_I) ? CMD_RANGE_I : CMD_RANGE_J;
      r.range_arg = arg2[2:0];
    end else if (ln_len == 3 && ln_head[0] == CH_I && ln_head[1] == CH_J
                 && arg3 < RANGE_LIMIT) begin
      r.cmd_code = CMD_RANGE_IJ;
      r.range_arg = arg3[2:0];
    end else if (ln_len == 3 && ln_head[0] == CH_Z
                 && (ln_head[1] == CH_I || ln_head[1] == CH_J)
                 && (ln_head[2] == CH_DIG_0 || ln_head[2] == CH_DIG_1)) begin
      r.cmd_code = CMD_ZERO;
      r.zero_channel = (ln_head[1] == CH_J);
      r.zero_on = (ln_head[2] == CH_DIG_1);
    end else if (ln_len > HEAD_LEN && ln_kw[KW_UPGRADE] && !ln_bad
                 && ln_seen[LAST_NUM]) begin
      r.cmd_code = CMD_UPGRADE;
      r.fw_version = ln_num[0];
      r.fw_size = ln_num[1];
      r.fw_crc = ln_num[2];
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] raw);
    logic [7:0] c;
    int pos;
    int k;
    string kw;
    c = raw;
    if (raw >= CH_LOW_A && raw <= CH_LOW_Z) c = raw - CASE_OFFSET;
    if (c == CH_CR || c == CH_LF) begin
      if (ln_len != 0 || ln_ovf) begin
        expected_cmds.push_back(decode_line_state());
        clear_line_state();
        bytes_used++;
      end
    end else if (ln_ovf || ln_len >= MAX_LINE - 1) begin
      if (!ln_ovf) bytes_used++;
      ln_ovf = 1'b1;
    end else begin
      pos = int'(ln_len);
      if (pos < HEAD_LEN) ln_head[pos] = c;
      for (k = 0; k < NUM_LIT; k++) begin
        kw = keyword_text(k);
        if (pos < kw.len()) begin
          if (c != kw[pos]) ln_kw[k] = 1'b0;
        end else if (k != KW_UPGRADE) begin
          ln_kw[k] = 1'b0;
        end
      end
      feed_upgrade_numbers(c);
      ln_len = ln_len + 7'd1;
      bytes_used++;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_decoded_cmd();
    result_t want;
    result_t got;
    got = {out_cmd_code, out_range_arg, out_zero_channel, out_zero_on,
           out_fw_version, out_fw_size, out_fw_crc};
    if (expected_cmds.size() == 0) begin
      $display("%0t: result beat with none expected, expected nothing, actual cmd_code %0d",
               $time, got.cmd_code);
      errors++;
    end else begin
      want = expected_cmds.pop_front();
      compare_field("cmd_code", 32'(want.cmd_code), 32'(got.cmd_code));
      compare_field("range_arg", 32'(want.range_arg), 32'(got.range_arg));
      compare_field("zero_channel", 32'(want.zero_channel), 32'(got.zero_channel));
      compare_field("zero_on", 32'(want.zero_on), 32'(got.zero_on));
      compare_field("fw_version", want.fw_version, got.fw_version);
      compare_field("fw_size", want.fw_size, got.fw_size);
      compare_field("fw_crc", want.fw_crc, got.fw_crc);
    end
  endtask

  // The receiver checks each accepted beat and then picks its stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_decoded_cmd();
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      rx_mode_left = $urandom_range(30, 150);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_ALT: out_stall <= ~out_stall;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_line(input logic [7:0] term);
    while (line_buf.size() != 0) send_rx_byte(line_buf.pop_front());
    send_rx_byte(term);
  endtask

  task automatic put_text(input string s, input bit mix_case);
    int i;
    logic [7:0] c;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
      line_buf.push_back(c);
    end
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    put_text(s, 1'b0);
    send_line(term);
  endtask

  task automatic put_blanks(input int lo, input int hi);
    int i;
    int n;
    n = $urandom_range(lo, hi);
    for (i = 0; i < n; i++) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic put_number();
    int i;
    int n;
    logic [7:0] d;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      d = CH_DIG_0 + 8'($urandom_range(0, 9));
      line_buf.push_back(d);
    end
  endtask

  task automatic put_random_bytes(input int lo, input int hi, input bit printable);
    int i;
    int n;
    logic [7:0] b;
    n = $urandom_range(lo, hi);
    for (i = 0; i < n; i++) begin
      b = printable ? 8'($urandom_range(8'h20, 8'h7e)) : 8'($urandom_range(0, 255));
      line_buf.push_back(b);
    end
  endtask

  task automatic put_fill(input int upto);
    while (line_buf.size() < upto) line_buf.push_back(CH_SPACE);
  endtask

  task automatic build_query_line();
    int flaw;
    logic [7:0] b;
    put_text(keyword_text($urandom_range(KW_IDN, KW_INFO)), 1'b1);
    flaw = $urandom_range(0, 9);
    b = 8'($urandom_range(0, 255));
    if (flaw == 0) line_buf.push_back(b);
    else if (flaw == 1) line_buf[$urandom_range(0, 4)] = b;
    else if (flaw == 2) void'(line_buf.pop_back());
  endtask

  task automatic build_range_line();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 2);
    if (pick == 0) put_text("I", 1'b1);
    else if (pick == 1) put_text("J", 1'b1);
    else put_text("IJ", 1'b1);
    if ($urandom_range(0, 4) < 3) b = CH_DIG_0 + 8'($urandom_range(0, 9));
    else b = 8'($urandom_range(0, 255));
    line_buf.push_back(b);
    if ($urandom_range(0, 7) == 0) put_random_bytes(1, 2, 1'b1);
  endtask

  task automatic build_zero_line();
    logic [7:0] b;
    put_text($urandom_range(0, 1) ? "ZI" : "ZJ", 1'b1);
    if ($urandom_range(0, 9) < 7) b = $urandom_range(0, 1) ? CH_DIG_1 : CH_DIG_0;
    else b = 8'($urandom_range(0, 255));
    line_buf.push_back(b);
  endtask

  task automatic build_upgrade_line();
    int i;
    int flaw;
    int which;
    logic [7:0] b;
    flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    which = $urandom_range(0, NUM_CNT - 1);
    put_text("UPGRADE", 1'b1);
    if ($urandom_range(0, 5) == 0) put_random_bytes(1, 3, 1'b1);
    put_blanks(1, 3);
    for (i = 0; i < NUM_CNT; i++) begin
      if (i > 0) begin
        if (flaw == 1 && i == which) line_buf.push_back(",");
        else put_blanks(1, 3);
      end
      if (flaw == 2 && i == which) line_buf.push_back($urandom_range(0, 1) ? "+" : "-");
      if (!(flaw == 3 && i == NUM_CNT - 1)) put_number();
    end
    if ($urandom_range(0, 2) == 0) begin
      b = "A";
      b = b + 8'($urandom_range(0, 25));
      line_buf.push_back(b);
      put_random_bytes(0, 6, 1'b1);
    end
    if (flaw == 4) begin
      b = 8'($urandom_range(0, 255));
      line_buf.insert($urandom_range(0, line_buf.size()), b);
    end
  endtask

  task automatic test_queries();
    send_text("*IDN?", CH_LF);
    send_text("meas?", CH_CR);
    send_text("Info?", CH_LF);
    send_text("*IDN", CH_LF);
    send_text("INFO?!", CH_CR);
    send_text("MEAS.", CH_LF);
  endtask

  task automatic test_ranges();
    send_text("I0", CH_LF);
    send_text("j5", CH_LF);
    send_text("I6", CH_CR);
    send_text("IJ3", CH_LF);
    send_text("ij9", CH_LF);
    // A letter counts by its low nibble, so P selects range zero.
    send_text("IP", CH_LF);
    line_buf.push_back(CH_J);
    line_buf.push_back(8'h00);
    send_line(CH_LF);
  endtask

  task automatic test_zero_cmds();
    send_text("ZI0", CH_LF);
    send_text("zj1", CH_CR);
    send_text("ZI2", CH_LF);
    send_text("ZJ", CH_LF);
  endtask

  task automatic test_upgrade_cmds();
    send_text("UPGRADE 1 2 3", CH_LF);
    send_text("upgrade\t4294967295 4294967296  007", CH_CR);
    send_text("UPGRADE 12 +3 4", CH_LF);
    send_text("UPGRADE 1 2", CH_LF);
    send_text("UPGRADEV2 10 20 30;x", CH_LF);
    send_text("UPGRADE 1,2 3", CH_LF);
    send_text("UPGRADE", CH_LF);
    send_text("UPGRADE 1 2 -3", CH_LF);
  endtask

  task automatic test_odd_lines();
    send_rx_byte(CH_LF);
    send_rx_byte(CH_CR);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'hff);
    line_buf.push_back(8'h7f);
    send_line(CH_CR);
    send_rx_byte(CH_LF);
    // The longest line that still decodes, then one character more.
    put_text("UPGRADE 7 8 9", 1'b0);
    put_fill(MAX_LINE - 1);
    send_line(CH_LF);
    put_text("UPGRADE 7 8 9", 1'b0);
    put_fill(MAX_LINE);
    send_line(CH_LF);
    put_text("I1", 1'b0);
    put_random_bytes(80, 90, 1'b1);
    send_line(CH_CR);
    send_text("I1", CH_LF);
  endtask

  task automatic test_output_hold();
    int i;
    sender_steady = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    for (i = 0; i < 16; i++) begin
      if (i[0]) send_text("ZJ1", CH_LF);
      else send_text("I2", CH_LF);
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_random_lines();
    int goal;
    int pick;
    goal = bytes_used + RANDOM_BYTES;
    while (bytes_used < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) build_query_line();
      else if (pick < 30) build_range_line();
      else if (pick < 40) build_zero_line();
      else if (pick < 72) build_upgrade_line();
      else if (pick < 84) put_random_bytes(0, 12, 1'b0);
      else if (pick < 88) put_random_bytes(58, 72, 1'b1);
      send_line($urandom_range(0, 1) ? CH_CR : CH_LF);
      if ($urandom_range(0, 9) == 0) send_rx_byte(CH_LF);
    end
  endtask

  initial begin
    clear_line_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_queries();
    test_ranges();
    test_zero_cmds();
    test_upgrade_cmds();
    test_odd_lines();
    test_output_hold();
    test_random_lines();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
